### design/jsp_pkg.sv
// Shared types and constants for the junction speed planner.
package jsp_pkg;

  // Fraction bits of speeds, accelerations, lengths and deviations. Every root
  // halves a doubled fraction, so the datapath does not depend on this value.
  localparam int SPEED_FRAC_BITS = 16;
  localparam logic signed [35:0] COS_LIMIT = 36'sd1073634450;
  localparam logic [31:0] JDEV_RESET = 32'd3277;

  localparam logic [1:0] REG_JDEV = 2'd0;
  localparam logic [1:0] REG_ZDEV = 2'd1;
  localparam logic [1:0] REG_ZEN = 2'd2;
  localparam logic [1:0] REG_MINSPD = 2'd3;

  // One classified segment, as handed from the front end to the back end.
  typedef struct packed {
    logic        corner;      // corner cap applies
    logic        limit_min;   // vmax starts from min(prev, nominal)
    logic [29:0] half;        // (2^30 - cos) / 2
    logic [31:0] dev;
    logic [31:0] pnom;
    logic [31:0] nominal;
    logic [31:0] accel;
    logic [31:0] seg_length;
    logic        primary;
  } seg_t;

endpackage

### design/jsp_sqrt.sv
// Iterative 64-bit integer square root, one result bit per cycle.
module jsp_sqrt import jsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [31:0] res;
  logic [5:0]  cnt;
  logic        busy;
  logic [65:0] trial;
  logic [65:0] shifted;

  // Radicand bits are consumed from the top through a shifting copy.
  logic [63:0] src;

  always_comb begin
    shifted = {rem, src[63:62]};
    trial = shifted - {32'd0, res, 2'b01};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      rem <= '0;
      res <= '0;
      src <= radicand;
    end else if (busy) begin
      src <= {src[61:0], 2'b00};
      if (!trial[65]) begin
        rem <= trial[63:0];
        res <= {res[30:0], 1'b1};
      end else begin
        rem <= shifted[63:0];
        res <= {res[30:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign root = res;

endmodule

### design/jsp_front.sv
// Front end: register port, segment classification and the cosine.
module jsp_front import jsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        steps_x,
  input  logic [23:0]        steps_y,
  input  logic [23:0]        steps_z,
  input  logic               has_direction,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic [31:0]        cruise_speed,
  input  logic [31:0]        accel,
  input  logic [31:0]        seg_length,
  output logic [31:0]        min_speed,
  output logic               q_valid,
  input  logic               q_ready,
  output seg_t               q_data
);

  logic [31:0] jdev, zdev, minspd;
  logic        zen;
  logic signed [15:0] pdx, pdy, pdz;
  logic [31:0] pspd;
  logic        pprim, havep;

  // Stage 1 holds the products; the queue register takes the classified segment.
  logic        s1_valid;
  logic signed [31:0] m_x, m_y, m_z;
  logic        s1_use;
  logic [31:0] s1_dev, s1_pnom;
  logic [31:0] s1_nominal, s1_accel, s1_len;
  logic        s1_prim;
  seg_t        q_next;

  logic [1:0] ra;
  assign ra = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      jdev <= JDEV_RESET;
      zdev <= '0;
      zen <= 1'b0;
      minspd <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ra)
        REG_JDEV:   jdev <= pwdata;
        REG_ZDEV:   zdev <= pwdata;
        REG_ZEN:    zen <= pwdata[0];
        REG_MINSPD: minspd <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (ra)
      REG_JDEV:   prdata = jdev;
      REG_ZDEV:   prdata = zdev;
      REG_ZEN:    prdata = {31'd0, zen};
      REG_MINSPD: prdata = minspd;
      default:    prdata = '0;
    endcase
  end
  assign min_speed = minspd;

  logic xy0, prim, acc_in;
  logic [31:0] dev_c;
  always_comb begin
    xy0 = (steps_x == '0) && (steps_y == '0);
    prim = !(xy0 && steps_z == '0);
    dev_c = (xy0 && steps_z != '0 && zen) ? zdev : jdev;
  end

  assign in_ready = !s1_valid && !(q_valid && !q_ready);
  assign acc_in = in_valid && in_ready;

  logic signed [35:0] cosv;
  logic [35:0] omc;
  assign cosv = -(36'(m_x) + 36'(m_y) + 36'(m_z));
  assign omc = 36'sd1073741824 - cosv;

  logic lim;
  always_comb begin
    lim = s1_use && s1_dev != '0 && s1_pnom != '0 && cosv <= COS_LIMIT;
    q_next.corner = lim && cosv >= -COS_LIMIT;
    q_next.limit_min = lim;
    q_next.half = omc[30:1];
    q_next.dev = s1_dev;
    q_next.pnom = s1_pnom;
    q_next.nominal = s1_nominal;
    q_next.accel = s1_accel;
    q_next.seg_length = s1_len;
    q_next.primary = s1_prim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      q_valid <= 1'b0;
      pdx <= '0; pdy <= '0; pdz <= '0;
      pspd <= '0; pprim <= 1'b0; havep <= 1'b0;
    end else begin
      // Stage 1 only fills while the queue is empty or draining, so it always
      // finds the queue free in the next cycle.
      if (s1_valid) begin
        q_valid <= 1'b1;
        q_data <= q_next;
      end else if (q_ready) begin
        q_valid <= 1'b0;
      end
      if (acc_in) begin
        s1_valid <= 1'b1;
        m_x <= 32'(pdx) * 32'(dir_x);
        m_y <= 32'(pdy) * 32'(dir_y);
        m_z <= 32'(pdz) * 32'(dir_z);
        s1_use <= has_direction && havep;
        s1_dev <= dev_c;
        s1_pnom <= pprim ? pspd : '0;
        s1_nominal <= cruise_speed;
        s1_accel <= accel;
        s1_len <= seg_length;
        s1_prim <= prim;
        pdx <= has_direction ? dir_x : '0;
        pdy <= has_direction ? dir_y : '0;
        pdz <= has_direction ? dir_z : '0;
        pspd <= cruise_speed;
        pprim <= prim;
        havep <= 1'b1;
      end else begin
        s1_valid <= 1'b0;
      end
    end
  end

endmodule

### design/jsp_back.sv
// Back end: corner cap, allowable speed and the result register.
module jsp_back import jsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] min_speed,
  input  logic        q_valid,
  output logic        q_ready,
  input  seg_t        q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] max_start_speed,
  output logic [31:0] start_speed,
  output logic        nominal_length,
  output logic        primary_axis
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SROOT = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_CAP   = 8'b0001_0000,
    ST_ALLOW = 8'b0010_0000,
    ST_AROOT = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t st;
  seg_t   sg;
  logic [31:0] vmax;
  logic [31:0] allow;
  logic [30:0] s;
  logic [63:0] num;   // accel*dev
  logic [94:0] prod;  // accel*dev*s
  logic [31:0] rem;
  logic [63:0] quo;
  logic        ovf;
  logic [6:0]  cnt;
  logic        sq_start, sq_done;
  logic [63:0] sq_in;
  logic [31:0] sq_root;

  jsp_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root)
  );

  assign q_ready = (st == ST_IDLE);

  logic [31:0] den;
  assign den = 32'd1073741824 - {1'b0, s};

  // 64x31 product built from two 32x31 halves.
  logic [63:0] p_lo, p_hi;
  assign p_lo = 64'(num[31:0]) * 64'(s);
  assign p_hi = 64'(num[63:32]) * 64'(s);

  logic [31:0] rsh;
  logic        fit;
  assign rsh = {rem[30:0], prod[94]};
  assign fit = (rsh >= den);

  logic [64:0] a2;
  logic [63:0] mm, asq;
  always_comb begin
    mm = 64'(min_speed) * 64'(min_speed);
    a2 = {1'b0, 64'(sg.accel) * 64'(sg.seg_length)};
    a2 = {a2[63:0], 1'b0};
    asq = a2[64] ? '1 : a2[63:0];
    asq = (asq > ~mm) ? '1 : asq + mm;
  end

  always_ff @(posedge clk) begin
    sq_start <= 1'b0;
    if (rst) begin
      st <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (st == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: if (q_valid) begin
          sg <= q_data;
          vmax <= q_data.limit_min ? ((q_data.pnom < q_data.nominal) ? q_data.pnom
                                      : q_data.nominal) : min_speed;
          if (q_data.corner) begin
            sq_in <= {4'd0, q_data.half, 30'd0};
            sq_start <= 1'b1;
            st <= ST_SROOT;
          end else st <= ST_ALLOW;
        end
        ST_SROOT: if (sq_done) begin
          s <= sq_root[30:0];
          num <= 64'(sg.accel) * 64'(sg.dev);
          st <= ST_MUL;
        end
        ST_MUL: begin
          prod <= 95'(p_lo) + {p_hi[62:0], 32'd0};
          rem <= '0;
          quo <= '0;
          ovf <= 1'b0;
          cnt <= '0;
          st <= ST_DIV;
        end
        ST_DIV: begin
          // Restoring division; a quotient bit above bit 63 saturates the result.
          rem <= fit ? rsh - den : rsh;
          quo <= {quo[62:0], fit};
          ovf <= ovf | quo[63];
          prod <= {prod[93:0], 1'b0};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd94) st <= ST_CAP;
        end
        ST_CAP: begin
          sq_in <= ovf ? '1 : quo;
          sq_start <= 1'b1;
          st <= ST_AROOT;
        end
        ST_ALLOW: begin
          sq_in <= asq;
          sq_start <= 1'b1;
          sg.corner <= 1'b0;
          st <= ST_AROOT;
        end
        ST_AROOT: if (sq_done) begin
          if (sg.corner) begin
            if (sq_root < vmax) vmax <= sq_root;
            st <= ST_ALLOW;
          end else begin
            allow <= sq_root;
            st <= ST_DONE;
          end
        end
        ST_DONE: if (!out_valid || out_ready) begin
          max_start_speed <= vmax;
          start_speed <= (allow < vmax) ? allow : vmax;
          nominal_length <= (sg.nominal <= allow);
          primary_axis <= sg.primary;
          st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/junction_speed_planner.sv
// Top level of the junction speed planner.
// For each segment the back end takes a bit-serial square root for the allowable
// speed, and for a corner cap two more roots and a restoring division. The front
// end classifies a segment through its stage 1 and queue registers and can take
// the next one while the back end works, and a held result keeps the back end
// waiting.
module junction_speed_planner import jsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        steps_x,
  input  logic [23:0]        steps_y,
  input  logic [23:0]        steps_z,
  input  logic               has_direction,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic [31:0]        cruise_speed,
  input  logic [31:0]        accel,
  input  logic [31:0]        seg_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        max_start_speed,
  output logic [31:0]        start_speed,
  output logic               nominal_length,
  output logic               primary_axis
);

  seg_t        qd;
  logic        qv, qr;
  logic [31:0] mins;

  assign pready = 1'b1;

  jsp_front u_front (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .in_valid, .in_ready, .steps_x, .steps_y, .steps_z, .has_direction,
    .dir_x, .dir_y, .dir_z, .cruise_speed, .accel, .seg_length,
    .min_speed(mins), .q_valid(qv), .q_ready(qr), .q_data(qd)
  );

  jsp_back u_back (
    .clk, .rst, .min_speed(mins), .q_valid(qv), .q_ready(qr), .q_data(qd),
    .out_valid, .out_ready, .max_start_speed, .start_speed, .nominal_length,
    .primary_axis
  );

endmodule
